// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros for the header field value finder
// every assertion is clocked on clk_i and disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge out of reset
`define HFVF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define HFVF_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define HFVF_ASSERT(lbl, prop, msg)
`define HFVF_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

// File: rtl/hfvf_pkg.sv
// ----------------------------------------------------------------------------
// hfvf_pkg
// types, character codes and register map shared by the header field finder
// ----------------------------------------------------------------------------
`default_nettype none

package hfvf_pkg;

  // character codes
  localparam logic [7:0] CharColon  = 8'h3a;
  localparam logic [7:0] CharLf     = 8'h0a;
  localparam logic [7:0] CharCr     = 8'h0d;
  localparam logic [7:0] CharTab    = 8'h09;
  localparam logic [7:0] CharSpace  = 8'h20;
  localparam logic [7:0] CharVt     = 8'h0b;
  localparam logic [7:0] CharFf     = 8'h0c;
  localparam logic [7:0] CharUpperA = 8'h41;
  localparam logic [7:0] CharUpperZ = 8'h5a;
  localparam logic [7:0] CaseOffset = 8'h20;

  // field name storage
  localparam int unsigned NameBytes = 16;
  localparam int unsigned NameBits  = 8 * NameBytes;
  localparam int unsigned NameSelW  = $clog2(NameBytes);
  localparam int unsigned NameLenW  = 5;

  // configuration port
  localparam int unsigned ApbAddrW = 5;
  localparam int unsigned ApbDataW = 64;
  localparam logic [1:0] RegNameLow  = 2'd0;
  localparam logic [1:0] RegNameHigh = 2'd1;
  localparam logic [1:0] RegNameLen  = 2'd2;

  // result status codes
  localparam logic [1:0] StFound    = 2'd0;
  localparam logic [1:0] StNotFound = 2'd1;
  localparam logic [1:0] StTooLong  = 2'd2;

  // one header byte as it arrives
  typedef struct packed {
    logic [7:0] hdr_byte;
    logic       last_byte;
  } hdr_item_t;

  // one lookup result
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] value_offset;
    logic [15:0] value_length;
  } result_t;

  // header byte after classification by the front end
  typedef struct packed {
    logic [7:0] lower_byte;
    logic       is_ws;
    logic       is_sp_tab;
    logic       is_colon;
    logic       is_lf;
    logic       is_cr;
    logic       first_eq;
    logic       last;
  } cls_t;

  // scan phase
  typedef enum logic [1:0] {
    PhSearch,
    PhSkipWs,
    PhValue,
    PhDone
  } phase_e;

  // ascii lower case
  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return ((c >= CharUpperA) && (c <= CharUpperZ)) ? (c + CaseOffset) : c;
  endfunction

endpackage

`default_nettype wire

// File: rtl/header_field_value_finder.sv
// ----------------------------------------------------------------------------
// header_field_value_finder
// streaming lookup of one field's value in a response header
// ----------------------------------------------------------------------------
// The block takes one header byte per clock on its push side and sustains
// that rate for as long as results are popped: a front end tags each byte
// with its character class, a small byte queue (QUEUE_DEPTH entries) carries
// it to the scanner, which updates its match and value tracking as each
// byte is taken. One result per header appears on the pop side the cycle
// after the byte marked last leaves the queue. The only stall is a final
// byte reaching the scanner while the previous header's result is still
// unread; the queue then fills and full rises. The field name (up to 16
// bytes, compared ignoring ASCII case) and its length are written over the
// APB port at byte addresses 0, 8 and 16; the user must write them only
// between headers, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module header_field_value_finder #(
  parameter int unsigned NAME_MAX_BYTES = 16,
  parameter int unsigned POSITION_BITS  = 16,
  parameter int unsigned QUEUE_DEPTH    = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [hfvf_pkg::ApbAddrW-1:0]   paddr,
  input  logic [hfvf_pkg::ApbDataW-1:0]   pwdata,
  output logic [hfvf_pkg::ApbDataW-1:0]   prdata,
  output logic                            pready,
  // header bytes
  input  logic                            push,
  output logic                            full,
  input  hfvf_pkg::hdr_item_t             hdr_item_i,
  // results
  output logic                            empty,
  input  logic                            pop,
  output hfvf_pkg::result_t               result_o
);

  logic [63:0]                   name_low_q;
  logic [63:0]                   name_high_q;
  logic [hfvf_pkg::NameLenW-1:0] name_len_q;
  logic [1:0]                    reg_idx;
  logic                          cfg_wr;

  hfvf_pkg::cls_t cls_wr, cls_rd;
  logic           fifo_wr, fifo_rd, fifo_empty;

  logic           res_miss, res_zero, res_bad_status;

  // configuration registers
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      name_low_q  <= '0;
      name_high_q <= '0;
      name_len_q  <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        hfvf_pkg::RegNameLow:  name_low_q  <= pwdata;
        hfvf_pkg::RegNameHigh: name_high_q <= pwdata;
        hfvf_pkg::RegNameLen:  name_len_q  <= pwdata[hfvf_pkg::NameLenW-1:0];
        default: begin
          name_len_q <= name_len_q;
        end
      endcase
    end
  end

  // register read back
  always_comb begin
    case (reg_idx)
      hfvf_pkg::RegNameLow:  prdata = name_low_q;
      hfvf_pkg::RegNameHigh: prdata = name_high_q;
      hfvf_pkg::RegNameLen:  prdata = hfvf_pkg::ApbDataW'(name_len_q);
      default:               prdata = '0;
    endcase
  end

  // front end
  hfvf_classify u_classify (
    .item_i       (hdr_item_i),
    .push_i       (push),
    .full_i       (full),
    .name_first_i (name_low_q[7:0]),
    .wr_en_o      (fifo_wr),
    .cls_o        (cls_wr)
  );

  // byte queue
  hfvf_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (fifo_wr),
    .wr_data_i (cls_wr),
    .full_o    (full),
    .rd_en_i   (fifo_rd),
    .rd_data_o (cls_rd),
    .empty_o   (fifo_empty)
  );

  // back end
  hfvf_scan #(
    .NAME_MAX_BYTES (NAME_MAX_BYTES),
    .POSITION_BITS  (POSITION_BITS)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .name_i      ({name_high_q, name_low_q}),
    .name_len_i  (name_len_q),
    .cls_i       (cls_rd),
    .cls_empty_i (fifo_empty),
    .cls_rd_o    (fifo_rd),
    .result_o    (result_o),
    .empty_o     (empty),
    .pop_i       (pop)
  );

  // result terms used by the checks
  assign res_miss       = !empty && (result_o.status != hfvf_pkg::StFound);
  assign res_zero       = (result_o.value_offset == 16'd0) &&
                          (result_o.value_length == 16'd0);
  assign res_bad_status = res_miss && (result_o.status != hfvf_pkg::StNotFound) &&
                          (result_o.status != hfvf_pkg::StTooLong);

  // assertions
  `HFVF_ASSERT(a_push_lands, push && !full |=> !fifo_empty, "accepted byte missing from queue")
  `HFVF_ASSERT(a_miss_zero, res_miss |-> res_zero, "nonzero bounds without a match")
  `HFVF_ASSERT_NEVER(a_status_code, res_bad_status, "undefined status code")

endmodule

`default_nettype wire

// File: rtl/hfvf_classify.sv
// ----------------------------------------------------------------------------
// hfvf_classify
// front end: accepts header bytes and tags them with character classes
// ----------------------------------------------------------------------------
`default_nettype none

module hfvf_classify (
  input  hfvf_pkg::hdr_item_t item_i,
  input  logic                push_i,
  input  logic                full_i,
  input  logic [7:0]          name_first_i,
  output logic                wr_en_o,
  output hfvf_pkg::cls_t      cls_o
);

  logic [7:0] b;

  assign b = item_i.hdr_byte;

  // accept when the queue has room
  assign wr_en_o = push_i & ~full_i;

  // character classes
  always_comb begin
    cls_o.lower_byte = hfvf_pkg::to_lower(b);
    cls_o.is_sp_tab  = (b == hfvf_pkg::CharSpace) || (b == hfvf_pkg::CharTab);
    cls_o.is_ws      = (b == hfvf_pkg::CharSpace) || (b == hfvf_pkg::CharTab) ||
                       (b == hfvf_pkg::CharLf) || (b == hfvf_pkg::CharVt) ||
                       (b == hfvf_pkg::CharFf) || (b == hfvf_pkg::CharCr);
    cls_o.is_colon   = (b == hfvf_pkg::CharColon);
    cls_o.is_lf      = (b == hfvf_pkg::CharLf);
    cls_o.is_cr      = (b == hfvf_pkg::CharCr);
    cls_o.first_eq   = (hfvf_pkg::to_lower(b) == hfvf_pkg::to_lower(name_first_i));
    cls_o.last       = item_i.last_byte;
  end

endmodule

`default_nettype wire

// File: rtl/hfvf_fifo.sv
// ----------------------------------------------------------------------------
// hfvf_fifo
// short queue of classified bytes between front end and scanner
// ----------------------------------------------------------------------------
`default_nettype none

module hfvf_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_en_i,
  input  hfvf_pkg::cls_t wr_data_i,
  output logic           full_o,
  input  logic           rd_en_i,
  output hfvf_pkg::cls_t rd_data_o,
  output logic           empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  hfvf_pkg::cls_t  mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_wr, do_rd;

  assign full_o    = (cnt_q == FullCnt);
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_en_i & ~full_o;
  assign do_rd     = rd_en_i & ~empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  // pointer and level update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : PtrW'(wr_ptr_q + 1'b1);
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : PtrW'(rd_ptr_q + 1'b1);
    end
    if (do_wr && !do_rd) begin
      cnt_d = CntW'(cnt_q + 1'b1);
    end else if (!do_wr && do_rd) begin
      cnt_d = CntW'(cnt_q - 1'b1);
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/hfvf_scan.sv
// ----------------------------------------------------------------------------
// hfvf_scan
// back end: walks the classified bytes, tracks the field match and value
// bounds, and holds the result in an output register
// ----------------------------------------------------------------------------
`default_nettype none

module hfvf_scan #(
  parameter int unsigned NAME_MAX_BYTES = 16,
  parameter int unsigned POSITION_BITS  = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [hfvf_pkg::NameBits-1:0]     name_i,
  input  logic [hfvf_pkg::NameLenW-1:0]     name_len_i,
  input  hfvf_pkg::cls_t                    cls_i,
  input  logic                              cls_empty_i,
  output logic                              cls_rd_o,
  output hfvf_pkg::result_t                 result_o,
  output logic                              empty_o,
  input  logic                              pop_i
);

  localparam int unsigned IdxW = $clog2(NAME_MAX_BYTES + 1);
  localparam int unsigned PosW = POSITION_BITS;
  localparam logic [PosW:0] MaxLen = {1'b0, {PosW{1'b1}}};

  // scan state
  hfvf_pkg::phase_e phase_q, phase_n, phase_d;
  logic [PosW:0]    pos_q, pos_d;
  logic             at_ls_q, at_ls_n, at_ls_d;
  logic [IdxW-1:0]  idx_q, idx_n, idx_d;
  logic             alive_q, alive_n, alive_d;
  logic             prev_cr_q, prev_cr_n, prev_cr_d;
  logic             pend_q, pend_n, pend_d;
  logic [PosW-1:0]  vstart_q, vstart_d;
  logic [PosW-1:0]  vend_q, vend_d;
  logic [PosW-1:0]  pnp_q, pnp_d;

  // output register
  logic              out_valid_q, out_valid_d;
  hfvf_pkg::result_t out_q;
  hfvf_pkg::result_t res;

  logic                          take, live, last_take, too_long;
  logic [IdxW-1:0]               eff_len;
  logic [hfvf_pkg::NameSelW-1:0] sel;
  logic [7:0]                    name_lc;
  logic                          idx_lt, alive_mid, colon_after, restart_ok;
  logic                          start_colon, start_name, to_skip;
  logic [PosW-1:0]               pos_lo, total;

  // take a byte unless a final byte would overwrite an unread result
  assign take      = ~cls_empty_i & (~cls_i.last | ~out_valid_q | pop_i);
  assign cls_rd_o  = take;
  assign last_take = take & cls_i.last;
  assign too_long  = (pos_q >= MaxLen);
  assign live      = take & ~too_long;
  assign pos_lo    = pos_q[PosW-1:0];
  assign total     = PosW'(pos_lo + PosW'(1));

  // effective name length and current name byte
  assign eff_len = (name_len_i > hfvf_pkg::NameLenW'(NAME_MAX_BYTES)) ?
                   IdxW'(NAME_MAX_BYTES) : IdxW'(name_len_i);
  assign sel     = hfvf_pkg::NameSelW'(idx_q);
  assign name_lc = hfvf_pkg::to_lower(name_i[{sel, 3'b000} +: 8]);

  // field name matching
  assign idx_lt      = (idx_q < eff_len);
  assign alive_mid   = alive_q & idx_lt & (cls_i.lower_byte == name_lc);
  assign colon_after = alive_q & ~idx_lt & cls_i.is_colon;
  assign restart_ok  = ~colon_after & ~alive_mid & at_ls_q & ~cls_i.is_ws;
  assign start_colon = restart_ok & (eff_len == '0) & cls_i.is_colon;
  assign start_name  = restart_ok & (eff_len != '0) & cls_i.first_eq;
  assign to_skip     = colon_after | start_colon;

  // next phase
  always_comb begin
    phase_n = phase_q;
    if (live) begin
      case (phase_q)
        hfvf_pkg::PhSearch: begin
          if (to_skip) phase_n = hfvf_pkg::PhSkipWs;
        end
        hfvf_pkg::PhSkipWs: begin
          if (!cls_i.is_ws) phase_n = hfvf_pkg::PhValue;
        end
        hfvf_pkg::PhValue: begin
          if (pend_q && !cls_i.is_sp_tab) phase_n = hfvf_pkg::PhDone;
        end
        hfvf_pkg::PhDone: begin
          phase_n = hfvf_pkg::PhDone;
        end
        default: begin
          phase_n = phase_q;
        end
      endcase
    end
    phase_d = last_take ? hfvf_pkg::PhSearch : phase_n;
  end

  // per-phase register updates
  always_comb begin
    at_ls_n   = at_ls_q;
    idx_n     = idx_q;
    alive_n   = alive_q;
    prev_cr_n = prev_cr_q;
    pend_n    = pend_q;
    vstart_d  = vstart_q;
    vend_d    = vend_q;
    pnp_d     = pnp_q;
    if (live) begin
      case (phase_q)
        hfvf_pkg::PhSearch: begin
          alive_n = alive_mid | start_name;
          if (start_name) begin
            idx_n = IdxW'(1);
          end else if (alive_mid) begin
            idx_n = IdxW'(idx_q + IdxW'(1));
          end
          at_ls_n = cls_i.is_lf;
        end
        hfvf_pkg::PhSkipWs: begin
          if (!cls_i.is_ws) begin
            vstart_d  = pos_lo;
            prev_cr_n = 1'b0;
            pend_n    = 1'b0;
          end
        end
        hfvf_pkg::PhValue: begin
          if (pend_q && !cls_i.is_sp_tab) begin
            pend_n = 1'b0;
            vend_d = PosW'(pnp_q - PosW'(prev_cr_q));
          end else if (cls_i.is_lf) begin
            pend_n = 1'b1;
            pnp_d  = pos_lo;
          end else begin
            pend_n    = 1'b0;
            prev_cr_n = cls_i.is_cr;
          end
        end
        default: begin
          at_ls_n = at_ls_q;
        end
      endcase
    end
  end

  // position counter saturates one past the longest header
  always_comb begin
    pos_d = pos_q;
    if (take) begin
      pos_d = pos_q[PosW] ? pos_q : (PosW + 1)'(pos_q + 1'b1);
    end
    at_ls_d   = at_ls_n;
    idx_d     = idx_n;
    alive_d   = alive_n;
    prev_cr_d = prev_cr_n;
    pend_d    = pend_n;
    if (last_take) begin
      pos_d     = '0;
      at_ls_d   = 1'b1;
      idx_d     = '0;
      alive_d   = 1'b0;
      prev_cr_d = 1'b0;
      pend_d    = 1'b0;
    end
  end

  // result of the header
  always_comb begin
    res.status       = hfvf_pkg::StFound;
    res.value_offset = '0;
    res.value_length = '0;
    if (too_long) begin
      res.status = hfvf_pkg::StTooLong;
    end else begin
      case (phase_n)
        hfvf_pkg::PhSkipWs: begin
          res.value_offset = 16'(total);
        end
        hfvf_pkg::PhValue: begin
          res.value_offset = 16'(vstart_d);
          res.value_length = 16'(PosW'(total - vstart_d));
        end
        hfvf_pkg::PhDone: begin
          res.value_offset = 16'(vstart_d);
          res.value_length = 16'(PosW'(vend_d - vstart_d));
        end
        default: begin
          res.status = hfvf_pkg::StNotFound;
        end
      endcase
    end
  end

  // output register valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (last_take) begin
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= hfvf_pkg::PhSearch;
      pos_q       <= '0;
      at_ls_q     <= 1'b1;
      idx_q       <= '0;
      alive_q     <= 1'b0;
      prev_cr_q   <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      pos_q       <= pos_d;
      at_ls_q     <= at_ls_d;
      idx_q       <= idx_d;
      alive_q     <= alive_d;
      prev_cr_q   <= prev_cr_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // value bounds and result payload
  always_ff @(posedge clk_i) begin
    vstart_q <= vstart_d;
    vend_q   <= vend_d;
    pnp_q    <= pnp_d;
    if (last_take) begin
      out_q <= res;
    end
  end

  assign result_o = out_q;
  assign empty_o  = ~out_valid_q;

endmodule

`default_nettype wire

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the header field value finder: streams directed
// and random response headers through the push side, predicts each lookup
// result in a cycle-free model and compares every popped transaction field
// by field, while the field name registers are reprogrammed between headers
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchdogLimit   = 2000;
  localparam int DrainCycles     = 16;
  localparam int HoldOffCycles   = 300;
  localparam int PhaseBytes      = 60;
  localparam int LongHeaderBytes = 300;

  // clock, reset and block inputs, all known from time zero
  logic                          clk_i      = 1'b0;
  logic                          rst_ni     = 1'b0;
  logic                          psel       = 1'b0;
  logic                          penable    = 1'b0;
  logic                          pwrite     = 1'b0;
  logic [hfvf_pkg::ApbAddrW-1:0] paddr      = '0;
  logic [hfvf_pkg::ApbDataW-1:0] pwdata     = '0;
  logic [hfvf_pkg::ApbDataW-1:0] prdata;
  logic                          pready;
  logic                          push       = 1'b0;
  logic                          full;
  hfvf_pkg::hdr_item_t           hdr_item_i = '0;
  logic                          empty;
  logic                          pop        = 1'b0;
  hfvf_pkg::result_t             result_o;

  header_field_value_finder dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .push       (push),
    .full       (full),
    .hdr_item_i (hdr_item_i),
    .empty      (empty),
    .pop        (pop),
    .result_o   (result_o)
  );

  // traffic shaping knobs
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int hold_cycles  = 0;
  int stall_cycles = 0;
  int err_count    = 0;

  // mirror of the field name registers
  logic [63:0] cfg_name_lo  = '0;
  logic [63:0] cfg_name_hi  = '0;
  logic [4:0]  cfg_name_len = '0;

  // scanner state of the lookup model
  logic              [16:0] scan_pos;
  logic                     scan_line_start;
  logic              [4:0]  scan_match_idx;
  logic                     scan_match_alive;
  hfvf_pkg::phase_e         scan_phase;
  logic              [15:0] scan_val_start;
  logic              [15:0] scan_val_end;
  logic                     scan_prev_cr;
  logic                     scan_nl_pending;
  logic              [15:0] scan_nl_pos;

  // lookups still owed by the block, and the header text being built
  hfvf_pkg::result_t lookup_q[$];
  logic [7:0]        hdr_buf[$];

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // lookup model
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    if ((c >= hfvf_pkg::CharUpperA) && (c <= hfvf_pkg::CharUpperZ)) begin
      return c + 8'd32;
    end
    return c;
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return (c == hfvf_pkg::CharSpace) || (c == hfvf_pkg::CharTab) ||
           (c == hfvf_pkg::CharLf) || (c == hfvf_pkg::CharVt) ||
           (c == hfvf_pkg::CharFf) || (c == hfvf_pkg::CharCr);
  endfunction

  function automatic int name_eff_len();
    return (cfg_name_len > hfvf_pkg::NameBytes) ? hfvf_pkg::NameBytes : int'(cfg_name_len);
  endfunction

  function automatic logic [7:0] cfg_name_byte(input int i);
    if (i < 8) begin
      return cfg_name_lo[8*i +: 8];
    end
    return cfg_name_hi[8*(i-8) +: 8];
  endfunction

  task automatic clear_scan();
    scan_pos         = '0;
    scan_line_start  = 1'b1;
    scan_match_idx   = '0;
    scan_match_alive = 1'b0;
    scan_phase       = hfvf_pkg::PhSearch;
    scan_val_start   = '0;
    scan_val_end     = '0;
    scan_prev_cr     = 1'b0;
    scan_nl_pending  = 1'b0;
    scan_nl_pos      = '0;
  endtask

  // advance the model by one header byte, queue a lookup on the last one
  task automatic scan_header_byte(input hfvf_pkg::hdr_item_t it);
    logic [7:0]        b;
    logic [4:0]        len;
    logic              too_long;
    logic [15:0]       p16;
    hfvf_pkg::result_t res;
    b        = it.hdr_byte;
    len      = 5'(name_eff_len());
    too_long = (scan_pos >= 17'd65535);
    p16      = scan_pos[15:0];
    scan_pos = too_long ? 17'h10000 : scan_pos + 17'd1;

    if (!too_long) begin
      case (scan_phase)
        hfvf_pkg::PhSearch: begin
          // finish or drop the current candidate
          if (scan_match_alive) begin
            if (scan_match_idx < len) begin
              if (fold_case(b) == fold_case(cfg_name_byte(int'(scan_match_idx)))) begin
                scan_match_idx = scan_match_idx + 5'd1;
              end else begin
                scan_match_alive = 1'b0;
              end
            end else begin
              scan_match_alive = 1'b0;
              if (b == hfvf_pkg::CharColon) scan_phase = hfvf_pkg::PhSkipWs;
            end
          end
          // a line start may open a new candidate
          if ((scan_phase == hfvf_pkg::PhSearch) && !scan_match_alive && scan_line_start &&
              !is_blank(b)) begin
            if (len == 5'd0) begin
              if (b == hfvf_pkg::CharColon) scan_phase = hfvf_pkg::PhSkipWs;
            end else if (fold_case(b) == fold_case(cfg_name_byte(0))) begin
              scan_match_alive = 1'b1;
              scan_match_idx   = 5'd1;
            end
          end
          scan_line_start = (b == hfvf_pkg::CharLf);
        end
        hfvf_pkg::PhSkipWs: begin
          if (!is_blank(b)) begin
            scan_val_start  = p16;
            scan_phase      = hfvf_pkg::PhValue;
            scan_prev_cr    = 1'b0;
            scan_nl_pending = 1'b0;
          end
        end
        hfvf_pkg::PhValue: begin
          // an lf not followed by space or tab closes the value
          if (scan_nl_pending && (b != hfvf_pkg::CharSpace) && (b != hfvf_pkg::CharTab)) begin
            scan_nl_pending = 1'b0;
            scan_val_end    = scan_nl_pos - {15'd0, scan_prev_cr};
            scan_phase      = hfvf_pkg::PhDone;
          end else begin
            scan_nl_pending = 1'b0;
            if (b == hfvf_pkg::CharLf) begin
              scan_nl_pending = 1'b1;
              scan_nl_pos     = p16;
            end else begin
              scan_prev_cr = (b == hfvf_pkg::CharCr);
            end
          end
        end
        default: ;
      endcase
    end

    if (it.last_byte) begin
      res = '{status: hfvf_pkg::StNotFound, value_offset: 16'd0, value_length: 16'd0};
      if (too_long) begin
        res.status = hfvf_pkg::StTooLong;
      end else if (scan_phase == hfvf_pkg::PhSkipWs) begin
        res.status       = hfvf_pkg::StFound;
        res.value_offset = p16 + 16'd1;
      end else if (scan_phase == hfvf_pkg::PhValue) begin
        res.status       = hfvf_pkg::StFound;
        res.value_offset = scan_val_start;
        res.value_length = p16 + 16'd1 - scan_val_start;
      end else if (scan_phase == hfvf_pkg::PhDone) begin
        res.status       = hfvf_pkg::StFound;
        res.value_offset = scan_val_start;
        res.value_length = scan_val_end - scan_val_start;
      end
      lookup_q.push_back(res);
      clear_scan();
    end
  endtask

  initial clear_scan();

  // ---------------------------------------------------------------------------
  // monitor, checker and watchdog
  // ---------------------------------------------------------------------------

  task automatic check_lookup(input hfvf_pkg::result_t got);
    hfvf_pkg::result_t want;
    if (lookup_q.size() == 0) begin
      $display("%0t: unexpected result status %0d offset %0d length %0d",
               $time, got.status, got.value_offset, got.value_length);
      err_count++;
      return;
    end
    want = lookup_q.pop_front();
    if (got.status !== want.status) begin
      $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
      err_count++;
    end
    if (got.value_offset !== want.value_offset) begin
      $display("%0t: value_offset expected %0d actual %0d",
               $time, want.value_offset, got.value_offset);
      err_count++;
    end
    if (got.value_length !== want.value_length) begin
      $display("%0t: value_length expected %0d actual %0d",
               $time, want.value_length, got.value_length);
      err_count++;
    end
  endtask

  // sample both handshakes at the edge, before the block updates
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      stall_cycles = 0;
    end else begin
      if (pop && !empty) check_lookup(result_o);
      if (push && !full) scan_header_byte(hdr_item_i);
      if ((pop && !empty) || (push && !full)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles = stall_cycles + 1;
      end
    end
  end

  initial begin
    while (stall_cycles < WatchdogLimit) @(posedge clk_i);
    $display("%0t: no transaction for %0d cycles", $time, WatchdogLimit);
    $display("tb_top failed");
    $finish;
  end

  // result side: random stalls plus an optional long hold-off
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        hold_cycles--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // one apb transfer: setup, access, then a return to idle
  task automatic apb_transfer(input logic wr, input logic [1:0] idx,
                              input logic [63:0] wdata, output logic [63:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 3'b000};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [63:0] data);
    logic [63:0] unused;
    apb_transfer(1'b1, idx, data, unused);
    case (idx)
      hfvf_pkg::RegNameLow:  cfg_name_lo  = data;
      hfvf_pkg::RegNameHigh: cfg_name_hi  = data;
      hfvf_pkg::RegNameLen:  cfg_name_len = data[4:0];
      default: ;
    endcase
  endtask

  task automatic check_register(input logic [1:0] idx, input logic [63:0] want);
    logic [63:0] got;
    apb_transfer(1'b0, idx, '0, got);
    if (idx == hfvf_pkg::RegNameLen) got = {59'd0, got[4:0]};
    if (got !== want) begin
      $display("%0t: register %0d expected %h actual %h", $time, idx, want, got);
      err_count++;
    end
  endtask

  // stop sending and let every owed lookup come out
  task automatic wait_idle();
    push <= 1'b0;
    @(posedge clk_i);
    while (lookup_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic program_name_regs(input logic [63:0] lo, input logic [63:0] hi,
                                   input logic [4:0] len);
    wait_idle();
    write_register(hfvf_pkg::RegNameLow, lo);
    write_register(hfvf_pkg::RegNameHigh, hi);
    write_register(hfvf_pkg::RegNameLen, {59'd0, len});
  endtask

  task automatic program_name_str(input string s, input logic [4:0] len);
    logic [127:0] nm;
    nm = '0;
    for (int i = 0; i < s.len(); i++) nm[8*i +: 8] = s[i];
    program_name_regs(nm[63:0], nm[127:64], len);
  endtask

  // offer one byte, return once it has been taken
  task automatic send_byte(input logic [7:0] b, input logic last);
    hfvf_pkg::hdr_item_t it;
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    it.hdr_byte  = b;
    it.last_byte = last;
    push       <= 1'b1;
    hdr_item_i <= it;
    do @(posedge clk_i); while (full);
  endtask

  task automatic send_header();
    for (int i = 0; i < hdr_buf.size(); i++) begin
      send_byte(hdr_buf[i], i == hdr_buf.size() - 1);
    end
    hdr_buf.delete();
  endtask

  // ---------------------------------------------------------------------------
  // header text builders
  // ---------------------------------------------------------------------------

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) hdr_buf.push_back(s[i]);
  endtask

  task automatic send_text(input string s);
    add_text(s);
    send_header();
  endtask

  function automatic logic [7:0] pick_ws();
    case ($urandom_range(5))
      0:       return hfvf_pkg::CharSpace;
      1:       return hfvf_pkg::CharTab;
      2:       return hfvf_pkg::CharCr;
      3:       return hfvf_pkg::CharLf;
      4:       return hfvf_pkg::CharVt;
      default: return hfvf_pkg::CharFf;
    endcase
  endfunction

  function automatic logic [7:0] pick_sp_tab();
    return ($urandom_range(1) == 1) ? hfvf_pkg::CharSpace : hfvf_pkg::CharTab;
  endfunction

  // first n bytes of the configured name, letters in random case
  task automatic add_name_text(input int n);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      b = cfg_name_byte(i);
      if (((fold_case(b) >= 8'h61) && (fold_case(b) <= 8'h7a)) &&
          ($urandom_range(1) == 1)) begin
        b = b ^ hfvf_pkg::CaseOffset;
      end
      hdr_buf.push_back(b);
    end
  endtask

  task automatic add_eol();
    int r;
    r = $urandom_range(9);
    if (r < 6) add_text("\r\n");
    else if (r < 9) hdr_buf.push_back(hfvf_pkg::CharLf);
    else add_text("\r\r\n");
  endtask

  task automatic add_value_chars(input int n);
    repeat (n) begin
      if ($urandom_range(9) == 0) hdr_buf.push_back(pick_sp_tab());
      else hdr_buf.push_back(8'($urandom_range(126, 33)));
    end
  endtask

  // value, sometimes folded onto a continuation line
  task automatic add_value();
    add_value_chars($urandom_range(6, 1));
    if ($urandom_range(3) == 0) begin
      add_eol();
      hdr_buf.push_back(pick_sp_tab());
      add_value_chars($urandom_range(4, 1));
    end
  endtask

  task automatic build_random_header();
    int lines;
    int eff;
    int l;
    eff   = name_eff_len();
    lines = $urandom_range(3, 1);
    // pure noise header
    if ($urandom_range(19) == 0) begin
      repeat ($urandom_range(10, 1)) hdr_buf.push_back(8'($urandom_range(255)));
      return;
    end
    for (l = 0; l < lines; l++) begin
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          add_name_text(eff);
          hdr_buf.push_back(hfvf_pkg::CharColon);
          repeat ($urandom_range(2)) hdr_buf.push_back(pick_ws());
          add_value();
        end
        4, 5: begin
          // near miss on the name
          case ($urandom_range(2))
            0: add_name_text((eff > 0) ? eff - 1 : 0);
            1: begin
              add_name_text(eff);
              hdr_buf.push_back(8'($urandom_range(122, 97)));
            end
            default: begin
              add_name_text(eff);
              hdr_buf.push_back(hfvf_pkg::CharSpace);
            end
          endcase
          hdr_buf.push_back(hfvf_pkg::CharColon);
          add_value();
        end
        6, 7: begin
          add_value_chars($urandom_range(5, 1));
          add_text(": ");
          add_value();
        end
        8: begin
          hdr_buf.push_back(pick_sp_tab());
          add_name_text(eff);
          hdr_buf.push_back(hfvf_pkg::CharColon);
          add_value();
        end
        default: repeat ($urandom_range(4, 1)) hdr_buf.push_back(8'($urandom_range(255)));
      endcase
      if (!((l == lines - 1) && ($urandom_range(3) == 0))) add_eol();
    end
    if ($urandom_range(2) == 0) add_text("\r\n");
  endtask

  // random register contents with a name-like prefix
  task automatic program_random_name();
    logic [127:0] nm;
    logic [4:0]   len;
    int           r;
    nm = {$urandom, $urandom, $urandom, $urandom};
    r  = $urandom_range(19);
    if (r == 0) len = 5'd0;
    else if (r < 3) len = 5'($urandom_range(31, 17));
    else len = 5'($urandom_range(16, 1));
    for (int i = 0; i < hfvf_pkg::NameBytes; i++) begin
      if ((i < len) && ($urandom_range(15) != 0)) begin
        case ($urandom_range(3))
          0:       nm[8*i +: 8] = 8'($urandom_range(90, 65));
          1:       nm[8*i +: 8] = 8'h2d;
          default: nm[8*i +: 8] = 8'($urandom_range(122, 97));
        endcase
      end
    end
    program_name_regs(nm[63:0], nm[127:64], len);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // register extremes with read-back, one header under each
  task automatic test_register_access();
    write_register(hfvf_pkg::RegNameLow, '1);
    write_register(hfvf_pkg::RegNameHigh, '1);
    write_register(hfvf_pkg::RegNameLen, '1);
    check_register(hfvf_pkg::RegNameLow, '1);
    check_register(hfvf_pkg::RegNameHigh, '1);
    check_register(hfvf_pkg::RegNameLen, 64'd31);
    repeat (hfvf_pkg::NameBytes) hdr_buf.push_back(8'hff);
    add_text(":z");
    send_header();
    wait_idle();
    write_register(hfvf_pkg::RegNameLow, '0);
    write_register(hfvf_pkg::RegNameHigh, '0);
    write_register(hfvf_pkg::RegNameLen, '0);
    check_register(hfvf_pkg::RegNameLow, '0);
    check_register(hfvf_pkg::RegNameHigh, '0);
    check_register(hfvf_pkg::RegNameLen, '0);
    send_text(":q\r\n");
  endtask

  // ordinary lookups: found, folded, missing, colon at the end, cr handling
  task automatic test_field_lookup();
    program_name_str("content-type", 5'd12);
    send_text("Content-Type: text/html\r\nHost: x\r\n\r\n");
    send_text("Host: a\r\ncontent-type:\tb\r\n c\r\n\td\r\nX: y");
    send_text("Server: none\r\n\r\n");
    send_text("CONTENT-TYPE:");
    send_text("content-type: \r\n");
    send_text(" content-type: no\r\ncontent-type:yes");
    send_text("content-typex: a\r\ncontent-type : b\r\nContent-type:v\n");
    send_text("content-type: a\r\r\nB: c");
    hdr_buf.push_back(8'h00);
    hdr_buf.push_back(8'hff);
    hdr_buf.push_back(8'h80);
    hdr_buf.push_back(8'h7f);
    send_header();
    send_text("x");
  endtask

  // empty name, full and oversized length, zero and lf bytes in the name
  task automatic test_name_corners();
    program_name_str("", 5'd0);
    send_text("a: b\r\n: c\r\n");
    send_text(" :x\r\n:\r\n");
    program_name_str("x-forwarded-host", 5'd16);
    send_text("X-Forwarded-Host: h\r\n");
    send_text("x-forwarded-hos: n\r\n");
    program_name_str("x-forwarded-host", 5'd31);
    send_text("x-forwarded-host:q");
    program_name_regs(64'h0000_0000_0062_0061, 64'h0, 5'd3);
    add_text("a");
    hdr_buf.push_back(8'h00);
    add_text("b:v\r\nab:w");
    send_header();
    program_name_regs(64'h0000_0000_0062_0a61, 64'h0, 5'd3);
    send_text("a\na\nb:v\r\n");
    program_name_str("KEY", 5'd3);
    send_text("key: 1\r\n");
  endtask

  // header longer than 256 bytes, so positions need more than 8 bits
  task automatic test_header_length();
    program_name_str("a", 5'd1);
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    for (int i = 0; i < LongHeaderBytes; i++) begin
      send_byte((i == 0) ? 8'h41 : (i == 1) ? hfvf_pkg::CharColon : 8'h76,
                i == LongHeaderBytes - 1);
    end
  endtask

  // random headers under one idling pattern, two name settings
  task automatic run_traffic_phase(input int tx_pct, input int rx_pct);
    int sent;
    for (int k = 0; k < 2; k++) begin
      program_random_name();
      tx_idle_pct  = tx_pct;
      rx_stall_pct = rx_pct;
      sent = 0;
      while (sent < PhaseBytes / 2) begin
        build_random_header();
        sent += hdr_buf.size();
        send_header();
      end
    end
  endtask

  task automatic test_random_traffic();
    run_traffic_phase(0, 0);
    run_traffic_phase(86, 0);
    run_traffic_phase(0, 86);
    run_traffic_phase(21, 21);
  endtask

  // results held back for a long stretch so the input side fills and stalls
  task automatic test_input_backpressure();
    program_name_str("a", 5'd1);
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_cycles  = HoldOffCycles;
    repeat (40) begin
      add_text("a:");
      add_value_chars($urandom_range(3, 1));
      send_header();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_register_access();
    test_field_lookup();
    test_name_corners();
    test_header_length();
    test_random_traffic();
    test_input_backpressure();
    wait_idle();
    if ((err_count == 0) && (lookup_q.size() == 0)) begin
      $display("tb_top passed");
    end else begin
      $display("%0t: %0d errors, %0d lookups outstanding",
               $time, err_count, lookup_q.size());
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
